FILE: rtl/core/lbsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbsw_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int SPREAD_BITS   = 4;
    localparam int OUT_IDX_BITS  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_LOW   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_HIGH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SPREAD = 2'd2;

    // Configuration reset values
    localparam logic signed [SAMPLE_BITS-1:0] BAND_LOW_RST   = 16'sd18;
    localparam logic signed [SAMPLE_BITS-1:0] BAND_HIGH_RST  = 16'sd24;
    localparam logic [SPREAD_BITS-1:0]        MAX_SPREAD_RST = 4'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in_word;

    typedef struct packed {
        logic                    report;
        logic                    clear_previous;
        logic [OUT_IDX_BITS-1:0] window_start;
        logic [OUT_IDX_BITS-1:0] window_end;
        logic                    stream_end;
        logic                    overflow;
    } t_out_word;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_MIN_RD   = 12'b0000_0000_0010,
        S_MIN_CHK  = 12'b0000_0000_0100,
        S_MIN_PUSH = 12'b0000_0000_1000,
        S_MIN_DROP = 12'b0000_0001_0000,
        S_MAX_RD   = 12'b0000_0010_0000,
        S_MAX_CHK  = 12'b0000_0100_0000,
        S_MAX_PUSH = 12'b0000_1000_0000,
        S_MAX_DROP = 12'b0001_0000_0000,
        S_LOOP_RD  = 12'b0010_0000_0000,
        S_LOOP_CHK = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/longest_bounded_spread_window_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data  (t_in_word)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_word)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An in-band word holds the input, accept to next accept, for the back pops over
// both deques, a compare on each deque still non-empty when its back scan stops,
// a push into each deque, a drop of the oldest entry from each full deque and the
// passes of the purge and spread loop, the last one included; each pop and each
// loop pass is one read of a deque memory and one compare. An out-of-band word
// goes straight to the final step. Reset is synchronous, active low; the deque
// memories are not cleared. A result waits in the output register; the sequencer
// holds in its final step only while that register is still full and stalled.

module longest_bounded_spread_window_unit #(
    parameter int INDEX_BITS  = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_in_valid,
    output logic                                      o_in_stall,
    input  wire  lbsw_pkg::t_in_word                  i_in_data,
    output logic                                      o_out_valid,
    input  wire                                       i_out_stall,
    output lbsw_pkg::t_out_word                       o_out_data,
    input  wire                                       i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire  [lbsw_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  wire  [lbsw_pkg::CFG_DATA_BITS-1:0]        i_cfg_data
);

    localparam int SB = lbsw_pkg::SAMPLE_BITS;
    localparam int OB = lbsw_pkg::OUT_IDX_BITS;
    localparam int IB = INDEX_BITS;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = QW + 1;
    localparam logic [IB-1:0] IDX_MAX   = {IB{1'b1}};
    localparam logic [AW-1:0] DEPTH_A   = AW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);

    // Control registers
    lbsw_pkg::t_state r_state, n_state;
    logic [IB:0]      r_pos, n_pos;
    logic [IB:0]      r_wl, n_wl;
    logic [IB:0]      r_best, n_best;
    logic [QW-1:0]    r_min_head, n_min_head, r_max_head, n_max_head;
    logic [CW-1:0]    r_min_cnt, n_min_cnt, r_max_cnt, n_max_cnt;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;
    logic signed [SB-1:0]                   r_band_low, r_band_high;
    logic [lbsw_pkg::SPREAD_BITS-1:0]       r_spread;

    // Payload registers
    logic [IB-1:0]        r_idx, n_idx;
    logic signed [SB-1:0] r_s, n_s;
    logic                 r_last, n_last;
    logic                 r_inband, n_inband;
    lbsw_pkg::t_out_word  r_out, n_out;

    // Deque memories and registered read data
    logic [IB-1:0]        min_mem_idx [QUEUE_DEPTH];
    logic signed [SB-1:0] min_mem_val [QUEUE_DEPTH];
    logic [IB-1:0]        max_mem_idx [QUEUE_DEPTH];
    logic signed [SB-1:0] max_mem_val [QUEUE_DEPTH];
    logic [IB-1:0]        r_min_ridx, r_max_ridx;
    logic signed [SB-1:0] r_min_rval, r_max_rval;

    logic          min_we, max_we;
    logic [QW-1:0] min_waddr, max_waddr, min_raddr, max_raddr;

    // Address arithmetic
    logic [AW-1:0] min_sum, max_sum, min_bsum, max_bsum;
    logic [QW-1:0] min_push_pos, max_push_pos, min_back_pos, max_back_pos;
    logic [QW-1:0] min_head_inc, max_head_inc;
    logic          min_full, max_full;

    always_comb begin
        min_sum  = AW'(r_min_head) + AW'(r_min_cnt);
        max_sum  = AW'(r_max_head) + AW'(r_max_cnt);
        min_bsum = min_sum - AW'(1);
        max_bsum = max_sum - AW'(1);
        min_push_pos = (min_sum >= DEPTH_A) ? QW'(min_sum - DEPTH_A) : QW'(min_sum);
        max_push_pos = (max_sum >= DEPTH_A) ? QW'(max_sum - DEPTH_A) : QW'(max_sum);
        min_back_pos = (min_bsum >= DEPTH_A) ? QW'(min_bsum - DEPTH_A) : QW'(min_bsum);
        max_back_pos = (max_bsum >= DEPTH_A) ? QW'(max_bsum - DEPTH_A) : QW'(max_bsum);
        min_head_inc = (r_min_head == LAST_SLOT) ? '0 : r_min_head + QW'(1);
        max_head_inc = (r_max_head == LAST_SLOT) ? '0 : r_max_head + QW'(1);
        min_full = (r_min_cnt == DEPTH_C);
        max_full = (r_max_cnt == DEPTH_C);
    end

    // Datapath helpers
    logic [IB-1:0]        idx_now;
    logic                 inband_now;
    logic [IB:0]          min_rd_next, max_rd_next, m_next, cur_idx, len;
    logic [IB-1:0]        m_idx;
    logic signed [SB:0]   diff;
    logic                 min_stale, max_stale;
    logic [IB+OB:0]       wl_wide, idx_wide;

    always_comb begin
        idx_now     = r_pos[IB] ? IDX_MAX : r_pos[IB-1:0];
        inband_now  = !((i_in_data.sample < r_band_low) || (i_in_data.sample > r_band_high));
        min_rd_next = {1'b0, r_min_ridx} + (IB+1)'(1);
        max_rd_next = {1'b0, r_max_ridx} + (IB+1)'(1);
        m_idx       = (r_min_ridx < r_max_ridx) ? r_min_ridx : r_max_ridx;
        m_next      = {1'b0, m_idx} + (IB+1)'(1);
        diff        = {r_max_rval[SB-1], r_max_rval} - {r_min_rval[SB-1], r_min_rval};
        min_stale   = (r_min_cnt != '0) && ({1'b0, r_min_ridx} < r_wl);
        max_stale   = (r_max_cnt != '0) && ({1'b0, r_max_ridx} < r_wl);
        cur_idx     = {1'b0, r_idx};
        len         = (cur_idx >= r_wl) ? cur_idx - r_wl + (IB+1)'(1) : '0;
        wl_wide     = {{OB{1'b0}}, r_wl};
        idx_wide    = {{(OB+1){1'b0}}, r_idx};
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_wl        = r_wl;
        n_best      = r_best;
        n_min_head  = r_min_head;
        n_max_head  = r_max_head;
        n_min_cnt   = r_min_cnt;
        n_max_cnt   = r_max_cnt;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_idx       = r_idx;
        n_s         = r_s;
        n_last      = r_last;
        n_inband    = r_inband;
        n_out       = r_out;
        min_we      = 1'b0;
        max_we      = 1'b0;
        min_waddr   = min_push_pos;
        max_waddr   = max_push_pos;
        min_raddr   = r_min_head;
        max_raddr   = r_max_head;

        // drop the output word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lbsw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (r_pos[IB]) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_pos = r_pos + (IB+1)'(1);
                    end
                    n_idx    = idx_now;
                    n_s      = i_in_data.sample;
                    n_last   = i_in_data.last_sample;
                    n_inband = inband_now;
                    if (!inband_now) begin
                        n_min_cnt  = '0;
                        n_max_cnt  = '0;
                        n_min_head = '0;
                        n_max_head = '0;
                        n_wl       = {1'b0, idx_now} + (IB+1)'(1);
                        n_state    = lbsw_pkg::S_DONE;
                    end else begin
                        n_state = lbsw_pkg::S_MIN_RD;
                    end
                end
            end
            lbsw_pkg::S_MIN_RD: begin
                min_raddr = min_back_pos;
                n_state = (r_min_cnt == '0) ? lbsw_pkg::S_MIN_PUSH : lbsw_pkg::S_MIN_CHK;
            end
            lbsw_pkg::S_MIN_CHK: begin
                if (r_min_rval >= r_s) begin
                    n_min_cnt = r_min_cnt - CW'(1);
                    n_state   = lbsw_pkg::S_MIN_RD;
                end else begin
                    n_state = lbsw_pkg::S_MIN_PUSH;
                end
            end
            lbsw_pkg::S_MIN_PUSH: begin
                min_we    = 1'b1;
                min_waddr = min_full ? r_min_head : min_push_pos;
                if (min_full) begin
                    n_min_head = min_head_inc;
                    n_state    = lbsw_pkg::S_MIN_DROP;
                end else begin
                    n_min_cnt = r_min_cnt + CW'(1);
                    n_state   = lbsw_pkg::S_MAX_RD;
                end
            end
            lbsw_pkg::S_MIN_DROP: begin
                if (min_rd_next > r_wl) begin
                    n_wl = min_rd_next;
                end
                n_state = lbsw_pkg::S_MAX_RD;
            end
            lbsw_pkg::S_MAX_RD: begin
                max_raddr = max_back_pos;
                n_state = (r_max_cnt == '0) ? lbsw_pkg::S_MAX_PUSH : lbsw_pkg::S_MAX_CHK;
            end
            lbsw_pkg::S_MAX_CHK: begin
                if (r_max_rval <= r_s) begin
                    n_max_cnt = r_max_cnt - CW'(1);
                    n_state   = lbsw_pkg::S_MAX_RD;
                end else begin
                    n_state = lbsw_pkg::S_MAX_PUSH;
                end
            end
            lbsw_pkg::S_MAX_PUSH: begin
                max_we    = 1'b1;
                max_waddr = max_full ? r_max_head : max_push_pos;
                if (max_full) begin
                    n_max_head = max_head_inc;
                    n_state    = lbsw_pkg::S_MAX_DROP;
                end else begin
                    n_max_cnt = r_max_cnt + CW'(1);
                    n_state   = lbsw_pkg::S_LOOP_RD;
                end
            end
            lbsw_pkg::S_MAX_DROP: begin
                if (max_rd_next > r_wl) begin
                    n_wl = max_rd_next;
                end
                n_state = lbsw_pkg::S_LOOP_RD;
            end
            lbsw_pkg::S_LOOP_RD: begin
                n_state = lbsw_pkg::S_LOOP_CHK;
            end
            lbsw_pkg::S_LOOP_CHK: begin
                // purge heads left of the window, then shrink until spread fits
                n_state = lbsw_pkg::S_LOOP_RD;
                if (min_stale) begin
                    n_min_head = min_head_inc;
                    n_min_cnt  = r_min_cnt - CW'(1);
                end else if (max_stale) begin
                    n_max_head = max_head_inc;
                    n_max_cnt  = r_max_cnt - CW'(1);
                end else if ((r_min_cnt == '0) || (r_max_cnt == '0)) begin
                    n_state = lbsw_pkg::S_DONE;
                end else if (diff <= $signed({{(SB-3){1'b0}}, r_spread})) begin
                    n_state = lbsw_pkg::S_DONE;
                end else begin
                    if (r_min_ridx <= r_max_ridx) begin
                        n_min_head = min_head_inc;
                        n_min_cnt  = r_min_cnt - CW'(1);
                    end
                    if (r_max_ridx <= r_min_ridx) begin
                        n_max_head = max_head_inc;
                        n_max_cnt  = r_max_cnt - CW'(1);
                    end
                    if (m_next > r_wl) begin
                        n_wl = m_next;
                    end
                end
            end
            lbsw_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out.report         = 1'b0;
                    n_out.clear_previous = 1'b0;
                    n_out.window_start   = '0;
                    n_out.window_end     = '0;
                    n_out.stream_end     = r_last;
                    n_out.overflow       = r_ovf;
                    if (r_inband && (len != '0) && (len >= r_best)) begin
                        n_out.report         = 1'b1;
                        n_out.clear_previous = (len > r_best);
                        n_out.window_start   = wl_wide[OB-1:0];
                        n_out.window_end     = idx_wide[OB-1:0];
                        n_best               = len;
                    end
                    // end of stream: return the stream counters and deques to their reset state
                    if (r_last) begin
                        n_pos      = '0;
                        n_wl       = '0;
                        n_best     = '0;
                        n_min_head = '0;
                        n_max_head = '0;
                        n_min_cnt  = '0;
                        n_max_cnt  = '0;
                        n_ovf      = 1'b0;
                    end
                    n_state = lbsw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lbsw_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbsw_pkg::S_IDLE;
            r_pos       <= '0;
            r_wl        <= '0;
            r_best      <= '0;
            r_min_head  <= '0;
            r_max_head  <= '0;
            r_min_cnt   <= '0;
            r_max_cnt   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_wl        <= n_wl;
            r_best      <= n_best;
            r_min_head  <= n_min_head;
            r_max_head  <= n_max_head;
            r_min_cnt   <= n_min_cnt;
            r_max_cnt   <= n_max_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low  <= lbsw_pkg::BAND_LOW_RST;
            r_band_high <= lbsw_pkg::BAND_HIGH_RST;
            r_spread    <= lbsw_pkg::MAX_SPREAD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lbsw_pkg::CFG_BAND_LOW:   r_band_low  <= $signed(i_cfg_data);
                lbsw_pkg::CFG_BAND_HIGH:  r_band_high <= $signed(i_cfg_data);
                lbsw_pkg::CFG_MAX_SPREAD: r_spread    <= i_cfg_data[lbsw_pkg::SPREAD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_s      <= n_s;
        r_last   <= n_last;
        r_inband <= n_inband;
        r_out    <= n_out;
    end

    // Min deque memory
    always_ff @(posedge i_clk) begin
        if (min_we) begin
            min_mem_idx[min_waddr] <= r_idx;
            min_mem_val[min_waddr] <= r_s;
        end
        r_min_ridx <= min_mem_idx[min_raddr];
        r_min_rval <= min_mem_val[min_raddr];
    end

    // Max deque memory
    always_ff @(posedge i_clk) begin
        if (max_we) begin
            max_mem_idx[max_waddr] <= r_idx;
            max_mem_val[max_waddr] <= r_s;
        end
        r_max_ridx <= max_mem_idx[max_raddr];
        r_max_rval <= max_mem_val[max_raddr];
    end

    assign o_in_stall  = (r_state != lbsw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min_cnt <= DEPTH_C) && (r_max_cnt <= DEPTH_C))
        else $error("deque count past depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in progress");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pos[IB] && (r_pos[IB-1:0] != '0)))
        else $error("index counter past saturation");

    a_clear_needs_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.clear_previous) |-> o_out_data.report)
        else $error("clear without report");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH        = 16;
    localparam int DRAIN_CYCLES = 200;
    localparam int MIN_Q        = 0;
    localparam int MAX_Q        = 1;
    localparam logic [16:0] INDEX_LIMIT = 17'd65535;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    lbsw_pkg::t_in_word   i_in_data   = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    lbsw_pkg::t_out_word  o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [lbsw_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [lbsw_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    // Stimulus knobs
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int mismatches   = 0;

    // Window tracker state, mirrored from the block
    logic signed [15:0] cfg_band_low  = lbsw_pkg::BAND_LOW_RST;
    logic signed [15:0] cfg_band_high = lbsw_pkg::BAND_HIGH_RST;
    logic [3:0]         cfg_spread    = lbsw_pkg::MAX_SPREAD_RST;
    logic [16:0]        next_index;
    logic [16:0]        win_start;
    logic [16:0]        best_len;
    logic               idx_sat;
    logic [15:0]        dq_idx [2][DEPTH];
    logic signed [15:0] dq_val [2][DEPTH];
    logic [3:0]         dq_head [2];
    logic [4:0]         dq_cnt [2];

    lbsw_pkg::t_out_word pending_results [$];
    lbsw_pkg::t_out_word want_word;

    longest_bounded_spread_window_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Window tracker
    // ---------------------------------------------------------------

    function automatic void clear_stream();
        next_index = '0;
        win_start  = '0;
        best_len   = '0;
        idx_sat    = 1'b0;
        for (int q = 0; q < 2; q++) begin
            dq_head[q] = '0;
            dq_cnt[q]  = '0;
        end
    endfunction

    function automatic logic [3:0] back_slot(int q);
        return 4'(dq_head[q] + dq_cnt[q] - 5'd1);
    endfunction

    function automatic void drop_head(int q);
        dq_head[q] = dq_head[q] + 4'd1;
        dq_cnt[q]  = dq_cnt[q] - 5'd1;
    endfunction

    // Push at the back; a full deque drops its oldest entry and the window
    // start moves past it.
    function automatic void push_entry(int q, logic [15:0] idx, logic signed [15:0] s);
        logic [15:0] dropped;
        logic [3:0]  slot;
        if (dq_cnt[q] == DEPTH) begin
            dropped = dq_idx[q][dq_head[q]];
            drop_head(q);
            if ({1'b0, dropped} + 17'd1 > win_start)
                win_start = {1'b0, dropped} + 17'd1;
        end
        slot = 4'(dq_head[q] + dq_cnt[q]);
        dq_idx[q][slot] = idx;
        dq_val[q][slot] = s;
        dq_cnt[q] = dq_cnt[q] + 5'd1;
    endfunction

    function automatic void purge_before(int q);
        while (dq_cnt[q] != 0 && {1'b0, dq_idx[q][dq_head[q]]} < win_start)
            drop_head(q);
    endfunction

    function automatic lbsw_pkg::t_out_word predict_window(lbsw_pkg::t_in_word w);
        lbsw_pkg::t_out_word r;
        logic [15:0]         idx;
        logic signed [15:0]  s;
        logic [16:0]         len;
        logic [15:0]         a;
        logic [15:0]         b;
        logic [15:0]         m;
        bit                  done;
        r = '0;
        s = w.sample;

        // Saturate the stream index
        if (next_index > INDEX_LIMIT) begin
            idx_sat = 1'b1;
            idx     = 16'hFFFF;
        end else begin
            idx        = next_index[15:0];
            next_index = next_index + 17'd1;
        end

        if (s < cfg_band_low || s > cfg_band_high) begin
            // Out of band: restart the segment at the next index
            dq_head[MIN_Q] = '0;
            dq_cnt[MIN_Q]  = '0;
            dq_head[MAX_Q] = '0;
            dq_cnt[MAX_Q]  = '0;
            win_start = {1'b0, idx} + 17'd1;
        end else begin
            while (dq_cnt[MIN_Q] != 0 && dq_val[MIN_Q][back_slot(MIN_Q)] >= s)
                dq_cnt[MIN_Q] = dq_cnt[MIN_Q] - 5'd1;
            push_entry(MIN_Q, idx, s);
            while (dq_cnt[MAX_Q] != 0 && dq_val[MAX_Q][back_slot(MAX_Q)] <= s)
                dq_cnt[MAX_Q] = dq_cnt[MAX_Q] - 5'd1;
            push_entry(MAX_Q, idx, s);

            // Shrink from the left until the spread fits
            done = 1'b0;
            while (!done) begin
                purge_before(MIN_Q);
                purge_before(MAX_Q);
                if (dq_cnt[MIN_Q] == 0 || dq_cnt[MAX_Q] == 0) begin
                    done = 1'b1;
                end else if (int'(dq_val[MAX_Q][dq_head[MAX_Q]])
                             - int'(dq_val[MIN_Q][dq_head[MIN_Q]]) <= int'(cfg_spread)) begin
                    done = 1'b1;
                end else begin
                    a = dq_idx[MIN_Q][dq_head[MIN_Q]];
                    b = dq_idx[MAX_Q][dq_head[MAX_Q]];
                    m = (a < b) ? a : b;
                    if (a == m)
                        drop_head(MIN_Q);
                    if (b == m)
                        drop_head(MAX_Q);
                    if ({1'b0, m} + 17'd1 > win_start)
                        win_start = {1'b0, m} + 17'd1;
                end
            end

            len = ({1'b0, idx} >= win_start) ? {1'b0, idx} - win_start + 17'd1 : '0;
            if (len != 0 && len >= best_len) begin
                r.report         = 1'b1;
                r.clear_previous = (len > best_len);
                r.window_start   = win_start[15:0];
                r.window_end     = idx;
                best_len         = len;
            end
        end

        r.stream_end = w.last_sample;
        r.overflow   = idx_sat;
        if (w.last_sample)
            clear_stream();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking and output stall
    // ---------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual %h",
                         $time, o_out_data);
            end else begin
                want_word = pending_results[0];
                pending_results.delete(0);
                check_field("report", want_word.report, o_out_data.report);
                check_field("clear_previous", want_word.clear_previous,
                            o_out_data.clear_previous);
                check_field("window_start", want_word.window_start, o_out_data.window_start);
                check_field("window_end", want_word.window_end, o_out_data.window_end);
                check_field("stream_end", want_word.stream_end, o_out_data.stream_end);
                check_field("overflow", want_word.overflow, o_out_data.overflow);
            end
        end
        // Hold off for a counted stretch, else stall at random
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Shared drivers
    // ---------------------------------------------------------------

    task automatic send_word(input logic signed [15:0] value, input logic last);
        lbsw_pkg::t_in_word w;
        w.sample      = value;
        w.last_sample = last;
        // Idle the sender cycle by cycle
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_results.insert(pending_results.size(), predict_window(w));
    endtask

    // Drop valid and wait until every expected word is back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back; upper spread bits are junk
    task automatic set_config(input logic signed [15:0] lo, input logic signed [15:0] hi,
                              input logic [3:0] spread);
        logic [lbsw_pkg::CFG_IDX_BITS-1:0]  reg_idx [3];
        logic [lbsw_pkg::CFG_DATA_BITS-1:0] reg_data [3];
        reg_idx[0]  = lbsw_pkg::CFG_BAND_LOW;
        reg_idx[1]  = lbsw_pkg::CFG_BAND_HIGH;
        reg_idx[2]  = lbsw_pkg::CFG_MAX_SPREAD;
        reg_data[0] = lo;
        reg_data[1] = hi;
        reg_data[2] = {12'($urandom), spread};
        wait_results_done();
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx[i];
            i_cfg_data  <= reg_data[i];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (reg_idx[i])
                lbsw_pkg::CFG_BAND_LOW:   cfg_band_low  = reg_data[i];
                lbsw_pkg::CFG_BAND_HIGH:  cfg_band_high = reg_data[i];
                lbsw_pkg::CFG_MAX_SPREAD: cfg_spread    = reg_data[i][3:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] to_sample(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset band 18..24, spread 4: growth, above-band break, tie, shrink
    task automatic test_default_band();
        send_word(16'sd20, 1'b0);
        send_word(16'sd20, 1'b0);
        send_word(16'sd30, 1'b0);
        send_word(16'sd20, 1'b0);
        send_word(16'sd20, 1'b0);
        send_word(16'sd18, 1'b0);
        send_word(16'sd24, 1'b1);
    endtask

    // Full-range band with zero spread, then a single-value band at the top
    task automatic test_band_extremes();
        set_config(16'sh8000, 16'sh7FFF, 4'd0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7FFF, 1'b1);
        set_config(16'sh7FFF, 16'sh7FFF, 4'd15);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh7FFE, 1'b0);
        send_word(16'sh7FFF, 1'b1);
    endtask

    // Low bound above high bound: nothing is ever in band
    task automatic test_inverted_band();
        set_config(16'sd5, -16'sd5, 4'd4);
        send_word(16'sd0, 1'b0);
        send_word(16'sd5, 1'b0);
        send_word(-16'sd5, 1'b1);
    endtask

    // A rising ramp under spread 15 fills the min deque and forces a drop
    task automatic test_deque_full();
        set_config(16'sd0, 16'sd100, 4'd15);
        for (int v = 0; v <= 16; v++)
            send_word(16'(v), v == 16);
    endtask

    // Long receiver hold-off while words keep coming, then a full pause
    task automatic test_backpressure();
        int cur;
        set_config(16'sd0, 16'sd30, 4'd6);
        cur = 15;
        hold_left = 400;
        repeat (30) begin
            send_word(to_sample(cur), 1'b0);
            cur = cur + int'($urandom_range(0, 6)) - 3;
        end
        wait_results_done();
        repeat (10) begin
            send_word(to_sample(cur), 1'b0);
            cur = cur + int'($urandom_range(0, 4)) - 2;
        end
        send_word(to_sample(cur), 1'b1);
    endtask

    // Mostly in-band walks and ramps, some noise and stream ends
    task automatic run_random(input logic signed [15:0] lo, input logic signed [15:0] hi,
                              input logic [3:0] spread, input int count);
        int sent;
        int kind;
        int run_len;
        int base;
        int cur;
        int k;
        int dir;
        set_config(lo, hi, spread);
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (cfg_band_low <= cfg_band_high)
                base = int'(cfg_band_low)
                       + int'($urandom_range(0, int'(cfg_band_high) - int'(cfg_band_low)));
            else
                base = int'($signed(16'($urandom)));
            cur = base;
            if (kind < 65) begin
                run_len = $urandom_range(1, 40);
                k = $urandom_range(1, int'(cfg_spread) + 2);
                repeat (run_len) begin
                    send_word(to_sample(cur), $urandom_range(199) == 0);
                    cur = cur + int'($urandom_range(0, 2 * k)) - k;
                end
            end else if (kind < 85) begin
                run_len = $urandom_range(5, 24);
                dir = $urandom_range(1) ? 1 : -1;
                repeat (run_len) begin
                    send_word(to_sample(cur), $urandom_range(199) == 0);
                    cur = cur + dir * int'($urandom_range(0, 2));
                end
            end else if (kind < 95) begin
                run_len = $urandom_range(1, 5);
                repeat (run_len)
                    send_word($signed(16'($urandom)), $urandom_range(9) == 0);
            end else begin
                run_len = 1;
                send_word(to_sample(base), 1'b1);
            end
            sent = sent + run_len;
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        clear_stream();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_band();
        test_band_extremes();
        test_inverted_band();
        test_deque_full();
        test_backpressure();

        send_gap_pct = 34;
        stall_pct    = 81;
        run_random(16'sh8000, 16'sh7FFF, 4'd15, 250);
        run_random(-16'sd40, 16'sd40, 4'd0, 250);

        send_gap_pct = 81;
        stall_pct    = 34;
        run_random(16'sd32700, 16'sh7FFF, 4'd9, 250);
        run_random(16'sh8000, -16'sd32740, 4'd3, 250);

        send_gap_pct = 0;
        stall_pct    = 0;
        run_random(16'sd10, -16'sd10, 4'd5, 100);
        run_random(16'sd100, 16'sd160, 4'd14, 400);

        wait_results_done();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: longest_bounded_spread_window_unit.f
rtl/core/lbsw_pkg.sv
rtl/core/longest_bounded_spread_window_unit.sv
sim/tb.sv
